[design/mm_pkg.sv]
// Shared types and constants for the matrix multiply core.
// No dependencies; every other design file but mm_ram takes its names from here.
`default_nettype none

package mm_pkg;

	localparam int FUNC_W    = 2;
	localparam int ROW_W     = 3;
	localparam int VAL_W     = 16;
	localparam int PROD_W    = 35;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int QDEPTH    = 2;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	localparam logic signed [PROD_W-1:0] PROD_MAX = {1'b0, {(PROD_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] PROD_MIN = {1'b1, {(PROD_W-1){1'b0}}};

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WR_A = 2'd0,
		FUNC_WR_B = 2'd1,
		FUNC_RUN  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_ROWS = 2'd0,
		CFG_A_COLS = 2'd1,
		CFG_B_ROWS = 2'd2,
		CFG_B_COLS = 2'd3
	} cfg_idx_t;

	// command kinds carried from front to back
	typedef enum logic [1:0] {
		CMD_WR_A = 2'd0,
		CMD_WR_B = 2'd1,
		CMD_RUN  = 2'd2,
		CMD_ERR  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic busy;
		logic pipe_empty;
	} back_status_t;

endpackage

`default_nettype wire

[design/mm_if.sv]
// Request and response channel interfaces of the matrix multiply core.
// Depends on mm_pkg for field widths.
`default_nettype none

interface mm_req_if;
	logic                              valid;
	logic                              ready;
	logic [mm_pkg::FUNC_W-1:0]         func;
	logic [mm_pkg::ROW_W-1:0]          row;
	logic [mm_pkg::ROW_W-1:0]          col;
	logic signed [mm_pkg::VAL_W-1:0]   value;

	modport source (output valid, func, row, col, value, input ready);
	modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface mm_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [mm_pkg::ROW_W-1:0]          out_row;
	logic [mm_pkg::ROW_W-1:0]          out_col;
	logic signed [mm_pkg::PROD_W-1:0]  product;
	logic                              last;
	logic                              size_error;

	modport source (output valid, out_row, out_col, product, last, size_error, input ready);
	modport sink   (input valid, out_row, out_col, product, last, size_error, output ready);
endinterface

`default_nettype wire

[design/matrix_multiply_core.sv]
// Matrix multiply core, C = A * B on signed Q8.8 elements of up to MAX_DIM by
// MAX_DIM, giving Q19.16 results saturated to 35 bits. Element writes (func 0
// for A, 1 for B) stream at one word per cycle while the command queue has
// room; a write outside the dimensions in use, or func 3, is taken and dropped.
// A compute word (func 2) yields C in row-major order with last on the final
// element, or a single size_error word when a_cols differs from b_rows. Each C
// element is summed over a_cols products on the single multiply-accumulate
// unit, as the A and B stores each give one element per cycle while the result
// side does not stall. A two-entry command queue lets writes queue behind a
// running product.
// Dimension registers read 0 as 1 and saturate at MAX_DIM; write them only
// while the core is idle. Depends on mm_pkg, mm_if, mm_ram, mm_queue,
// mm_front and mm_back.
`default_nettype none

module matrix_multiply_core #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	mm_req_if.sink                              req,
	mm_rsp_if.source                            rsp,
	input  wire logic                           cfg_wr_en,
	input  wire logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mm_pkg::CFG_W-1:0]       cfg_data
);

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
	localparam int CMD_W = 2 + AW + ELEM_WIDTH;

	logic [mm_pkg::CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [IDX_W-1:0]         ar_last, ac_last, br_last, bc_last;

	logic                  push, q_full, q_not_empty, pop;
	mm_pkg::cmd_kind_t     f_kind;
	logic [AW-1:0]         f_addr;
	logic [ELEM_WIDTH-1:0] f_data;
	logic [CMD_W-1:0]      q_out;
	mm_pkg::cmd_kind_t     b_kind;
	mm_pkg::back_status_t  status;

	function automatic logic [IDX_W-1:0] dim_last(input logic [mm_pkg::CFG_W-1:0] v);
		logic [IDX_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (32'(v) > MAX_DIM) begin
			r = IDX_W'(MAX_DIM - 1);
		end else begin
			r = IDX_W'(v - 1'b1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= mm_pkg::DIM_RESET;
			a_cols_q <= mm_pkg::DIM_RESET;
			b_rows_q <= mm_pkg::DIM_RESET;
			b_cols_q <= mm_pkg::DIM_RESET;
		end else if (cfg_wr_en) begin
			case (mm_pkg::cfg_idx_t'(cfg_index))
				mm_pkg::CFG_A_ROWS: a_rows_q <= cfg_data;
				mm_pkg::CFG_A_COLS: a_cols_q <= cfg_data;
				mm_pkg::CFG_B_ROWS: b_rows_q <= cfg_data;
				mm_pkg::CFG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ar_last = dim_last(a_rows_q);
	assign ac_last = dim_last(a_cols_q);
	assign br_last = dim_last(b_rows_q);
	assign bc_last = dim_last(b_cols_q);

	mm_front #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_front (
		.req     (req),
		.ar_last (ar_last),
		.ac_last (ac_last),
		.br_last (br_last),
		.bc_last (bc_last),
		.q_full  (q_full),
		.push    (push),
		.kind    (f_kind),
		.addr    (f_addr),
		.data    (f_data)
	);

	mm_queue #(.WIDTH(CMD_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_kind, f_addr, f_data}),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_data  (q_out)
	);

	assign b_kind = mm_pkg::cmd_kind_t'(q_out[CMD_W-1 -: 2]);

	mm_back #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd_kind  (b_kind),
		.cmd_addr  (q_out[ELEM_WIDTH +: AW]),
		.cmd_data  (q_out[ELEM_WIDTH-1:0]),
		.cmd_pop   (pop),
		.ar_last   (ar_last),
		.ac_last   (ac_last),
		.bc_last   (bc_last),
		.rsp       (rsp),
		.status    (status)
	);

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.size_error |-> rsp.last && (rsp.product == '0))
		else $error("size_error word without last or with nonzero product");

	a_err_drained: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (b_kind == mm_pkg::CMD_ERR) |-> status.pipe_empty && !status.busy)
		else $error("size_error issued while a product was still in flight");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status.busy) |-> $past(pop && (b_kind == mm_pkg::CMD_RUN)))
		else $error("product sequencer started without a compute command");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("command popped from empty queue");

endmodule

`default_nettype wire

[design/mm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while rd_en is low. No dependencies.
`default_nettype none

module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[design/mm_queue.sv]
// Short command queue between the front and back of the matrix multiply core.
// Depends on mm_pkg for its depth.
`default_nettype none

module mm_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic      [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(mm_pkg::QDEPTH);
	localparam int CNT_W = $clog2(mm_pkg::QDEPTH + 1);

	logic [WIDTH-1:0] slot_q [mm_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(mm_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(mm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(mm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/mm_front.sv]
// Front end: accepts request words, drops out-of-range writes and unused
// codes, and turns the rest into queue commands. Depends on mm_pkg, mm_if.
`default_nettype none

module mm_front #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	mm_req_if.sink                                   req,
	input  wire logic [$clog2(MAX_DIM)-1:0]          ar_last,
	input  wire logic [$clog2(MAX_DIM)-1:0]          ac_last,
	input  wire logic [$clog2(MAX_DIM)-1:0]          br_last,
	input  wire logic [$clog2(MAX_DIM)-1:0]          bc_last,
	input  wire logic                                q_full,
	output logic                                     push,
	output mm_pkg::cmd_kind_t                        kind,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       addr,
	output logic [ELEM_WIDTH-1:0]                    data
);

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	logic in_a;
	logic in_b;
	logic keep;

	assign in_a = (32'(req.row) <= 32'(ar_last)) && (32'(req.col) <= 32'(ac_last));
	assign in_b = (32'(req.row) <= 32'(br_last)) && (32'(req.col) <= 32'(bc_last));

	always_comb begin
		kind = mm_pkg::CMD_RUN;
		keep = 1'b0;
		case (req.func)
			mm_pkg::FUNC_WR_A: begin
				kind = mm_pkg::CMD_WR_A;
				keep = in_a;
			end
			mm_pkg::FUNC_WR_B: begin
				kind = mm_pkg::CMD_WR_B;
				keep = in_b;
			end
			mm_pkg::FUNC_RUN: begin
				kind = (ac_last == br_last) ? mm_pkg::CMD_RUN : mm_pkg::CMD_ERR;
				keep = 1'b1;
			end
			default: begin
				kind = mm_pkg::CMD_RUN;
				keep = 1'b0;
			end
		endcase
	end

	// only meaningful for in-range writes
	assign addr = AW'(32'(req.row) * MAX_DIM + 32'(req.col));
	assign data = ELEM_WIDTH'(req.value);

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full && keep;

endmodule

`default_nettype wire

[design/mm_back.sv]
// Back end: applies element writes to the A and B stores and runs the
// product sequencer, multiply/accumulate pipeline and output register.
// Depends on mm_pkg, mm_if and mm_ram.
`default_nettype none

module mm_back #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cmd_valid,
	input  wire mm_pkg::cmd_kind_t                   cmd_kind,
	input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  cmd_addr,
	input  wire logic [ELEM_WIDTH-1:0]               cmd_data,
	output logic                                     cmd_pop,
	input  wire logic [$clog2(MAX_DIM)-1:0]          ar_last,
	input  wire logic [$clog2(MAX_DIM)-1:0]          ac_last,
	input  wire logic [$clog2(MAX_DIM)-1:0]          bc_last,
	mm_rsp_if.source                                 rsp,
	output mm_pkg::back_status_t                     status
);

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int MUL_W = 2 * ELEM_WIDTH;
	localparam int ACC_W = (MUL_W + IDX_W + 1 > mm_pkg::PROD_W + 1) ?
		MUL_W + IDX_W + 1 : mm_pkg::PROD_W + 1;
	localparam int UP_W  = ACC_W - mm_pkg::PROD_W + 1;

	// sequencer
	logic             busy_q;
	logic [IDX_W-1:0] r_q, c_q, k_q;
	logic             stall;
	logic             fire;

	// pipeline
	logic                    valid_s1, first_s1, kend_s1, lastrun_s1;
	logic [IDX_W-1:0]        r_s1, c_s1;
	logic                    valid_s2, first_s2, kend_s2, lastrun_s2;
	logic [IDX_W-1:0]        r_s2, c_s2;
	logic signed [MUL_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] sum;
	logic [UP_W-1:0]         sum_up;
	logic signed [mm_pkg::PROD_W-1:0] sum_sat;

	logic [ELEM_WIDTH-1:0] a_rd, b_rd;
	logic [AW-1:0]         a_rd_addr, b_rd_addr;
	logic                  wr_a, wr_b, start, out_load, err_load;

	// output register
	logic                             out_valid_q;
	logic [mm_pkg::ROW_W-1:0]         out_row_q, out_col_q;
	logic signed [mm_pkg::PROD_W-1:0] product_q;
	logic                             last_q, size_error_q;

	assign stall    = valid_s2 && kend_s2 && out_valid_q && !rsp.ready;
	assign fire     = busy_q && !stall;

	assign wr_a     = cmd_valid && !busy_q && (cmd_kind == mm_pkg::CMD_WR_A);
	assign wr_b     = cmd_valid && !busy_q && (cmd_kind == mm_pkg::CMD_WR_B);
	assign start    = cmd_valid && !busy_q && (cmd_kind == mm_pkg::CMD_RUN);
	// mismatch word goes out only once earlier results have drained
	assign err_load = cmd_valid && !busy_q && (cmd_kind == mm_pkg::CMD_ERR) &&
		!valid_s1 && !valid_s2 && (!out_valid_q || rsp.ready);
	assign cmd_pop  = wr_a || wr_b || start || err_load;

	assign a_rd_addr = AW'(32'(r_q) * MAX_DIM + 32'(k_q));
	assign b_rd_addr = AW'(32'(k_q) * MAX_DIM + 32'(c_q));

	mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (cmd_addr),
		.wr_data (cmd_data),
		.rd_en   (!stall),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd)
	);

	mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (cmd_addr),
		.wr_data (cmd_data),
		.rd_en   (!stall),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			r_q    <= '0;
			c_q    <= '0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			r_q    <= '0;
			c_q    <= '0;
			k_q    <= '0;
		end else if (fire) begin
			if (k_q == ac_last) begin
				k_q <= '0;
				if (c_q == bc_last) begin
					c_q <= '0;
					if (r_q == ar_last) begin
						busy_q <= 1'b0;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end else begin
					c_q <= c_q + 1'b1;
				end
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= busy_q;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			first_s1   <= (k_q == '0);
			kend_s1    <= (k_q == ac_last);
			lastrun_s1 <= (r_q == ar_last) && (c_q == bc_last);
			r_s1       <= r_q;
			c_s1       <= c_q;
			first_s2   <= first_s1;
			kend_s2    <= kend_s1;
			lastrun_s2 <= lastrun_s1;
			r_s2       <= r_s1;
			c_s2       <= c_s1;
			prod_s2    <= $signed(a_rd) * $signed(b_rd);
		end
		if (valid_s2 && !stall) begin
			acc_q <= sum;
		end
	end

	assign acc_base = first_s2 ? '0 : acc_q;
	assign sum      = acc_base + ACC_W'(prod_s2);
	assign sum_up   = sum[ACC_W-1:mm_pkg::PROD_W-1];

	always_comb begin
		if ((&sum_up) || !(|sum_up)) begin
			sum_sat = sum[mm_pkg::PROD_W-1:0];
		end else if (sum[ACC_W-1]) begin
			sum_sat = mm_pkg::PROD_MIN;
		end else begin
			sum_sat = mm_pkg::PROD_MAX;
		end
	end

	assign out_load = valid_s2 && kend_s2 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load || err_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q    <= mm_pkg::ROW_W'(r_s2);
			out_col_q    <= mm_pkg::ROW_W'(c_s2);
			product_q    <= sum_sat;
			last_q       <= lastrun_s2;
			size_error_q <= 1'b0;
		end else if (err_load) begin
			out_row_q    <= '0;
			out_col_q    <= '0;
			product_q    <= '0;
			last_q       <= 1'b1;
			size_error_q <= 1'b1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_row    = out_row_q;
	assign rsp.out_col    = out_col_q;
	assign rsp.product    = product_q;
	assign rsp.last       = last_q;
	assign rsp.size_error = size_error_q;

	assign status.busy       = busy_q;
	assign status.pipe_empty = !valid_s1 && !valid_s2;

endmodule

`default_nettype wire
